// ===== rtl/circular_list_position_engine_top_assert.svh =====
// Assertion macros shared by the circular list engine modules
`ifndef CIRCULAR_LIST_POSITION_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_LIST_POSITION_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/clpe_pkg.sv =====
// Shared command and status codes for the circular list engine
package clpe_pkg;

  localparam int unsigned VALW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DEL_REAR = 2'd1,
    CMD_DEL_AT   = 2'd2,
    CMD_SEARCH   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

endpackage

// ===== rtl/clpe_node_mem.sv =====
// Node pool memory: value, forward link and backward link per node
module clpe_node_mem #(
  parameter int unsigned IDXW = 6,
  parameter int unsigned ROWW = 44
) (
  input  logic            clk,
  input  logic [IDXW-1:0] rd_addr,
  output logic [ROWW-1:0] rd_data,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_addr,
  input  logic [ROWW-1:0] wr_data
);

  logic [ROWW-1:0] mem [(1 << IDXW)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-entry collision
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/clpe_free_pool.sv =====
// Free node pool: high-water counter plus a stack of released nodes
`include "circular_list_position_engine_top_assert.svh"

module clpe_free_pool #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IDXW     = 6,
  parameter int unsigned CNTW     = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            alloc,
  input  logic            release_en,
  input  logic [IDXW-1:0] rel_node,
  output logic [IDXW-1:0] node
);

  logic [IDXW-1:0] stk [(1 << IDXW)];
  logic [CNTW-1:0] sp;
  logic [CNTW-1:0] hw;
  logic [IDXW-1:0] top_data;
  logic            stk_vld;
  logic [CNTW-1:0] sp_m1;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] wr_addr;

  assign sp_m1   = sp - CNTW'(1);
  assign rd_addr = sp_m1[IDXW-1:0];
  assign wr_addr = sp[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (release_en) begin
      stk[wr_addr] <= rel_node;
    end
    if (release_en && (wr_addr == rd_addr)) begin
      top_data <= rel_node;
    end else begin
      top_data <= stk[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      hw      <= '0;
      stk_vld <= 1'b0;
    end else begin
      stk_vld <= !(alloc || release_en);
      if (release_en) begin
        sp <= sp + CNTW'(1);
      end else if (alloc) begin
        if (sp != '0) begin
          sp <= sp_m1;
        end else begin
          hw <= hw + CNTW'(1);
        end
      end
    end
  end

  // recycled nodes first, then never-used ones
  assign node = (sp != '0) ? top_data : hw[IDXW-1:0];

  `CLPE_ASSERT_NOW(a_pop_data_fresh, alloc && (sp != '0), stk_vld, "stack top read stale")
  `CLPE_ASSERT_NOW(a_no_overalloc, alloc && (sp == '0), hw < CNTW'(CAPACITY), "pool overrun")
  `CLPE_ASSERT_NOW(a_alloc_rel_excl, release_en, !alloc, "alloc and release together")

endmodule

// ===== rtl/circular_list_position_engine_top.sv =====
// Circular doubly linked list engine, top level and command sequencer
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  in      | in_valid/in_stall  | command, value, position
//  out     | out_valid/out_stall| status, found_position, list_length
//
// One request at a time. A walk follows one forward link per cycle out of
// the node memory (one read port, registered read), so the walk grows with
// the position: insert walks to position-1 (length-1 at the head), delete
// to the position (length-1 from the rear), search up to the match index;
// an insert into an empty list and a reject need no walk.
// No clearing pass after reset: the node store is only read along links,
// and the free pool uses a fill count. The result waits in an output
// register; a new request is accepted while it is stalled, and the next
// result waits in DONE until it is taken.
`include "circular_list_position_engine_top_assert.svh"

module circular_list_position_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  input  logic [6:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [5:0]         found_position,
  output logic [6:0]         list_length
);

  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CNTW > 7) ? CNTW : 7;
  localparam int unsigned VALW = clpe_pkg::VALW;
  localparam int unsigned ROWW = VALW + 2 * IDXW;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_INS_EMPTY, S_I1, S_I2, S_I3, S_D1, S_D2, S_D3, S_DONE
  } state_t;

  state_t            state;
  logic [CNTW-1:0]   cnt;        // entries in the list
  logic [IDXW-1:0]   head;
  logic [IDXW-1:0]   cur;        // node under the walk
  logic [CNTW-1:0]   steps;      // links still to follow
  logic [CNTW-1:0]   idx;        // position of cur
  logic              is_search;
  logic              is_insert;
  logic              at_head;    // request touches position zero
  logic [VALW-1:0]   val_q;
  logic [ROWW-1:0]   row_q;
  logic [IDXW-1:0]   n_q;        // freshly allocated node
  logic [2:0]        status_q;
  logic [5:0]        found_q;

  logic [IDXW-1:0]   rd_addr;
  logic [ROWW-1:0]   rd_data;
  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  logic [ROWW-1:0]   wr_data;
  logic              alloc;
  logic              release_en;
  logic [IDXW-1:0]   free_node;

  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cnt_x;
  logic [6:0]        pos_m1;
  logic [CNTW-1:0]   cnt_m1;
  logic              out_free;

  // row fields
  logic [VALW-1:0]   rd_val;
  logic [IDXW-1:0]   rd_fwd;
  logic [IDXW-1:0]   rd_bwd;
  logic [VALW-1:0]   q_val;
  logic [IDXW-1:0]   q_fwd;
  logic [IDXW-1:0]   q_bwd;

  assign rd_val = rd_data[ROWW-1 -: VALW];
  assign rd_fwd = rd_data[2*IDXW-1 -: IDXW];
  assign rd_bwd = rd_data[IDXW-1:0];
  assign q_val  = row_q[ROWW-1 -: VALW];
  assign q_fwd  = row_q[2*IDXW-1 -: IDXW];
  assign q_bwd  = row_q[IDXW-1:0];

  assign pos_x    = CMPW'(position);
  assign cnt_x    = CMPW'(cnt);
  assign pos_m1   = position - 7'd1;
  assign cnt_m1   = cnt - CNTW'(1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  clpe_node_mem #(.IDXW(IDXW), .ROWW(ROWW)) u_node_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  clpe_free_pool #(.CAPACITY(CAPACITY), .IDXW(IDXW), .CNTW(CNTW)) u_free_pool (
    .clk        (clk),
    .rst        (rst),
    .alloc      (alloc),
    .release_en (release_en),
    .rel_node   (cur),
    .node       (free_node)
  );

  // memory port steering: L = cur, R = forward of L, c = cur when deleting
  always_comb begin
    rd_addr    = head;
    wr_en      = 1'b0;
    wr_addr    = cur;
    wr_data    = row_q;
    alloc      = 1'b0;
    release_en = 1'b0;
    unique case (state)
      S_IDLE: rd_addr = head;
      S_WALK: rd_addr = rd_fwd;
      S_INS_EMPTY: begin
        alloc   = 1'b1;
        wr_en   = 1'b1;
        wr_addr = free_node;
        wr_data = {val_q, free_node, free_node};
      end
      S_I1: begin
        alloc   = 1'b1;
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = {q_val, free_node, q_bwd};
      end
      S_I2: begin
        rd_addr = q_fwd;
        wr_en   = 1'b1;
        wr_addr = n_q;
        wr_data = {val_q, q_fwd, cur};
      end
      S_I3: begin
        wr_en   = 1'b1;
        wr_addr = q_fwd;
        wr_data = {rd_val, rd_fwd, n_q};
      end
      S_D1: rd_addr = q_bwd;
      S_D2: begin
        rd_addr = q_fwd;
        wr_en   = 1'b1;
        wr_addr = q_bwd;
        wr_data = {rd_val, q_fwd, rd_bwd};
      end
      S_D3: begin
        release_en = 1'b1;
        wr_en      = 1'b1;
        wr_addr    = q_fwd;
        wr_data    = {rd_val, rd_fwd, q_bwd};
      end
      S_DONE: rd_addr = head;
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val_q     <= value;
            cur       <= head;
            idx       <= '0;
            found_q   <= '0;
            status_q  <= clpe_pkg::ST_OK;
            is_search <= 1'b0;
            is_insert <= 1'b0;
            at_head   <= 1'b0;
            state     <= S_DONE;
            unique case (clpe_pkg::cmd_t'(command))
              clpe_pkg::CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                  status_q <= clpe_pkg::ST_BAD_POS;
                end else if (cnt == CNTW'(CAPACITY)) begin
                  status_q <= clpe_pkg::ST_FULL;
                end else if (cnt == '0) begin
                  state <= S_INS_EMPTY;
                end else begin
                  // insert after node L; at the head L is the last node
                  is_insert <= 1'b1;
                  at_head   <= (position == 7'd0);
                  steps     <= (position == 7'd0) ? cnt_m1 : CNTW'(pos_m1);
                  state     <= S_WALK;
                end
              end
              clpe_pkg::CMD_DEL_REAR: begin
                if (cnt == '0) begin
                  status_q <= clpe_pkg::ST_EMPTY;
                end else begin
                  at_head <= (cnt_m1 == '0);
                  steps   <= cnt_m1;
                  state   <= S_WALK;
                end
              end
              clpe_pkg::CMD_DEL_AT: begin
                if (pos_x >= cnt_x) begin
                  status_q <= clpe_pkg::ST_BAD_POS;
                end else begin
                  at_head <= (position == 7'd0);
                  steps   <= CNTW'(position);
                  state   <= S_WALK;
                end
              end
              clpe_pkg::CMD_SEARCH: begin
                if (cnt == '0) begin
                  status_q <= clpe_pkg::ST_EMPTY;
                end else begin
                  is_search <= 1'b1;
                  state     <= S_WALK;
                end
              end
              default: status_q <= clpe_pkg::ST_BAD_POS;
            endcase
          end
        end
        S_WALK: begin
          // rd_data holds the row of cur
          if (is_search) begin
            if (rd_val == val_q) begin
              found_q <= 6'(idx);
              state   <= S_DONE;
            end else if (idx == cnt_m1) begin
              status_q <= clpe_pkg::ST_NOT_FOUND;
              state    <= S_DONE;
            end else begin
              cur <= rd_fwd;
              idx <= idx + CNTW'(1);
            end
          end else if (steps == '0) begin
            row_q <= rd_data;
            state <= is_insert ? S_I1 : S_D1;
          end else begin
            cur   <= rd_fwd;
            steps <= steps - CNTW'(1);
          end
        end
        S_INS_EMPTY: begin
          head  <= free_node;
          cnt   <= cnt + CNTW'(1);
          state <= S_DONE;
        end
        S_I1: begin
          n_q <= free_node;
          if (at_head) begin
            head <= free_node;
          end
          state <= S_I2;
        end
        S_I2: state <= S_I3;
        S_I3: begin
          cnt   <= cnt + CNTW'(1);
          state <= S_DONE;
        end
        S_D1: state <= S_D2;
        S_D2: state <= S_D3;
        S_D3: begin
          if (at_head) begin
            head <= q_fwd;
          end
          cnt   <= cnt_m1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= status_q;
            found_position <= found_q;
            list_length    <= 7'(cnt);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CLPE_ASSERT_NEXT(a_ins_grows, state == S_I3, cnt == $past(cnt) + CNTW'(1), "insert count")
  `CLPE_ASSERT_NEXT(a_del_shrinks, state == S_D3, cnt == $past(cnt) - CNTW'(1), "delete count")
  `CLPE_ASSERT_NEXT(a_done_emits, (state == S_DONE) && out_free, out_valid, "result dropped")

endmodule
